// ----- rtl/sasc_pkg.sv -----
// Shared types and constants for the superheat adaptive step control block.
// No dependencies; imported by sasc_step_logic and the top level.
`default_nettype none

package sasc_pkg;

    typedef enum logic [1:0] {
        DIR_BACK = 2'd0,
        DIR_HOLD = 2'd1,
        DIR_FWD  = 2'd2
    } dir_t;

    localparam logic [1:0] CFG_DISCHARGE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_DEADBAND        = 2'd1;
    localparam logic [1:0] CFG_INITIAL_STEP    = 2'd2;
    localparam logic [1:0] CFG_MIN_POSITION    = 2'd3;

    localparam logic [11:0] DISCHARGE_LIMIT_RST = 12'd1000;
    localparam logic [6:0]  DEADBAND_RST        = 7'd5;
    localparam logic [8:0]  INITIAL_STEP_RST    = 9'd16;
    localparam logic [8:0]  MIN_POSITION_RST    = 9'd120;
    localparam logic [2:0]  RESTORE_COUNT       = 3'd4;

    typedef struct packed {
        logic [11:0] discharge_limit;
        logic [6:0]  deadband;
        logic [8:0]  initial_step;
        logic [8:0]  min_position;
    } cfg_t;

    typedef struct packed {
        logic [8:0]  valve_position;
        logic [11:0] superheat_target;
        logic [11:0] saturation_temp;
        logic [11:0] inlet_temp;
        logic [11:0] discharge_temp;
    } item_t;

    typedef struct packed {
        dir_t       dir;
        logic [2:0] count;
        logic [8:0] step;
    } ctl_state_t;

    typedef struct packed {
        logic              valid;
        logic signed [12:0] step_command;
        logic              over_limit;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/sasc_step_logic.sv -----
// One control tick: over-limit check, superheat direction tracking, step sizing.
// Depends on sasc_pkg; purely combinational.
`default_nettype none

module sasc_step_logic (
    input  wire sasc_pkg::item_t      item,
    input  wire sasc_pkg::cfg_t       cfg,
    input  wire sasc_pkg::ctl_state_t cur,
    output sasc_pkg::ctl_state_t      nxt,
    output sasc_pkg::result_t         res
);
    import sasc_pkg::*;

    logic signed [12:0] excess;
    logic               over;
    logic signed [13:0] sub;
    logic signed [13:0] band_hi;
    logic signed [13:0] band_lo;
    dir_t               want;
    dir_t               prev;
    logic [2:0]         cnt_n;
    logic [8:0]         step_n;
    logic signed [11:0] cmd;
    logic signed [11:0] reach;
    logic               above_min;

    always_comb begin
        over   = $signed(item.discharge_temp) > $signed(cfg.discharge_limit);
        excess = $signed({item.discharge_temp[11], item.discharge_temp})
               - $signed({cfg.discharge_limit[11], cfg.discharge_limit});

        sub = $signed({{2{item.inlet_temp[11]}}, item.inlet_temp})
            - $signed({{2{item.saturation_temp[11]}}, item.saturation_temp});
        band_hi = $signed({{2{item.superheat_target[11]}}, item.superheat_target})
                + $signed({7'd0, cfg.deadband});
        band_lo = $signed({{2{item.superheat_target[11]}}, item.superheat_target})
                - $signed({7'd0, cfg.deadband});

        if (sub > band_hi) begin
            want = DIR_FWD;
        end else if (sub < band_lo) begin
            want = DIR_BACK;
        end else begin
            want = DIR_HOLD;
        end

        if (cur.dir == DIR_FWD || cur.dir == DIR_HOLD) begin
            prev = cur.dir;
        end else begin
            prev = DIR_BACK;
        end

        cnt_n  = cur.count;
        step_n = cur.step;
        if (want == DIR_HOLD) begin
            cnt_n = '0;
        end else if (prev == DIR_HOLD || prev == want) begin
            cnt_n = cur.count + 3'd1;
        end else begin
            step_n = cur.step >> 1;
        end

        if (cnt_n >= RESTORE_COUNT && want != DIR_HOLD) begin
            step_n = cfg.initial_step;
            cnt_n  = '0;
        end
        if (step_n <= 9'd1) begin
            step_n = 9'd1;
        end

        if (want == DIR_BACK) begin
            cmd = -$signed({3'd0, step_n});
        end else begin
            cmd = $signed({3'd0, step_n});
        end
        reach     = cmd + $signed({3'd0, item.valve_position});
        above_min = reach >= $signed({3'd0, cfg.min_position});

        if (over) begin
            nxt              = cur;
            res.valid        = 1'b1;
            res.step_command = excess;
            res.over_limit   = 1'b1;
        end else begin
            nxt.dir          = want;
            nxt.count        = cnt_n;
            nxt.step         = step_n;
            res.valid        = (want != DIR_HOLD) && above_min;
            res.step_command = {cmd[11], cmd};
            res.over_limit   = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/superheat_adaptive_step_control_unit.sv -----
// Superheat adaptive step control: top level with config registers and stream ports.
// Depends on sasc_pkg and sasc_step_logic.
// An accepted input word passes the input register and then the output register before its result word is valid.
// Throughput: one word per cycle while m_tready does not hold off the output; the tracking state updates as a
// word leaves the input register. A tick that yields no result is dropped at that point.
// Reset (aresetn low, synchronous): config registers to defaults, direction hold, step 16.
`default_nettype none

module superheat_adaptive_step_control_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // discharge_temp[11:0], inlet_temp[23:12], saturation_temp[35:24],
    // superheat_target[47:36], valve_position[56:48], zero pad[63:57]
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // step_command[12:0], zero pad[15:13]
    output logic [15:0]      m_tdata,
    // over_limit[0]
    output logic [0:0]       m_tuser
);
    import sasc_pkg::*;

    cfg_t               cfg_reg;
    ctl_state_t         state_reg;
    ctl_state_t         state_next;
    item_t              item_reg;
    logic               item_valid_reg;
    logic               out_valid_reg;
    logic signed [12:0] out_cmd_reg;
    logic               out_over_reg;
    result_t            res;
    logic               advance;

    assign advance  = item_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;

    sasc_step_logic u_step (
        .item (item_reg),
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.discharge_limit <= DISCHARGE_LIMIT_RST;
            cfg_reg.deadband        <= DEADBAND_RST;
            cfg_reg.initial_step    <= INITIAL_STEP_RST;
            cfg_reg.min_position    <= MIN_POSITION_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DISCHARGE_LIMIT: cfg_reg.discharge_limit <= cfg_data;
                CFG_DEADBAND:        cfg_reg.deadband        <= cfg_data[6:0];
                CFG_INITIAL_STEP:    cfg_reg.initial_step    <= cfg_data[8:0];
                CFG_MIN_POSITION:    cfg_reg.min_position    <= cfg_data[8:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            item_reg <= s_tdata[56:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.dir   <= DIR_HOLD;
            state_reg.count <= '0;
            state_reg.step  <= INITIAL_STEP_RST;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= advance && res.valid;
        end
        if (advance && res.valid) begin
            out_cmd_reg  <= res.step_command;
            out_over_reg <= res.over_limit;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {3'd0, out_cmd_reg};
    assign m_tuser[0] = out_over_reg;

endmodule

`default_nettype wire

// ----- bench/superheat_adaptive_step_control_unit_tb.sv -----
// Self-checking bench for superheat_adaptive_step_control_unit: predicts each valve step word
// from the accepted control ticks and the register settings, and compares it field by field.
// Depends on sasc_pkg and the RTL of the block; needs nothing else.
module superheat_adaptive_step_control_unit_tb;
    import sasc_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int TICKS_PER_PHASE = 183;
    localparam int NUM_PHASES = 7;
    localparam int LONG_HOLD_CYCLES = 120;

    class valve_command_tracker;
        dir_t               direction;
        logic [2:0]         same_dir_count;
        logic [8:0]         step_size;
        logic signed [11:0] limit_reg;
        logic [6:0]         band_reg;
        logic [8:0]         init_step_reg;
        logic [8:0]         min_pos_reg;
        result_t            pending_commands[$];
        int errors;
        int ticks;
        int words;
        int over_words;
        int reversals;
        int restores;
        int below_min;

        function new();
            direction      = DIR_HOLD;
            same_dir_count = '0;
            step_size      = INITIAL_STEP_RST;
            limit_reg      = DISCHARGE_LIMIT_RST;
            band_reg       = DEADBAND_RST;
            init_step_reg  = INITIAL_STEP_RST;
            min_pos_reg    = MIN_POSITION_RST;
        endfunction

        function void set_reg(logic [1:0] idx, logic [11:0] data);
            case (idx)
                CFG_DISCHARGE_LIMIT: limit_reg = data;
                CFG_DEADBAND:        band_reg = data[6:0];
                CFG_INITIAL_STEP:    init_step_reg = data[8:0];
                CFG_MIN_POSITION:    min_pos_reg = data[8:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_commands.size();
        endfunction

        function void note_tick(item_t it);
            int      dis;
            int      lim;
            int      superheat;
            int      tgt;
            int      bandv;
            int      cmd;
            dir_t    want;
            dir_t    prev;
            result_t r;
            ticks++;
            dis = $signed(it.discharge_temp);
            lim = limit_reg;
            r.valid = 1'b1;
            if (dis > lim) begin
                r.step_command = 13'(dis - lim);
                r.over_limit = 1'b1;
                pending_commands.push_back(r);
                return;
            end
            superheat = $signed(it.inlet_temp) - $signed(it.saturation_temp);
            tgt = $signed(it.superheat_target);
            bandv = band_reg;
            if (superheat > tgt + bandv) want = DIR_FWD;
            else if (superheat < tgt - bandv) want = DIR_BACK;
            else want = DIR_HOLD;

            if (want == DIR_HOLD) begin
                same_dir_count = '0;
            end else begin
                prev = (direction == DIR_HOLD || direction == DIR_FWD) ? direction : DIR_BACK;
                if (prev == DIR_HOLD || prev == want) begin
                    same_dir_count = same_dir_count + 3'd1;
                end else begin
                    step_size = step_size >> 1;
                    reversals++;
                end
            end
            direction = want;
            if (same_dir_count >= RESTORE_COUNT && want != DIR_HOLD) begin
                step_size = init_step_reg;
                same_dir_count = '0;
                restores++;
            end
            if (step_size <= 9'd1) step_size = 9'd1;

            cmd = (want == DIR_HOLD) ? 0 : int'(step_size);
            if (want == DIR_BACK) cmd = -cmd;
            if (cmd == 0) return;
            if (cmd + int'(it.valve_position) < int'(min_pos_reg)) begin
                below_min++;
                return;
            end
            r.step_command = 13'(cmd);
            r.over_limit = 1'b0;
            pending_commands.push_back(r);
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_word(logic signed [12:0] cmd, logic over);
            result_t exp_r;
            words++;
            if (over) over_words++;
            if (pending_commands.size() == 0) begin
                report($sformatf("unexpected word: step_command %0d over_limit %0b", cmd, over));
                return;
            end
            exp_r = pending_commands.pop_front();
            if (cmd !== exp_r.step_command)
                report($sformatf("word %0d: step_command %0d, expected %0d",
                                 words, cmd, exp_r.step_command));
            if (over !== exp_r.over_limit)
                report($sformatf("word %0d: over_limit %0b, expected %0b",
                                 words, over, exp_r.over_limit));
        endtask

        task flush_leftovers();
            while (pending_commands.size() != 0) begin
                report($sformatf("missing word: step_command %0d over_limit %0b",
                                 pending_commands[0].step_command,
                                 pending_commands[0].over_limit));
                void'(pending_commands.pop_front());
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_DISCHARGE_LIMIT;
    logic [11:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [63:0] s_tdata = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire [15:0]  m_tdata;
    wire [0:0]   m_tuser;

    valve_command_tracker sb = new();

    int   cfg_limit = 1000;
    int   cfg_band = 5;
    dir_t last_want = DIR_FWD;
    bit   no_gaps = 1'b0;
    bit   long_hold_req = 1'b0;

    int ph_limit[NUM_PHASES] = '{1000, 2047, -2048, 0, 1500, -1000, 1000};
    int ph_band[NUM_PHASES]  = '{5, 0, 127, 10, 50, 0, 5};
    int ph_init[NUM_PHASES]  = '{16, 1, 511, 0, 500, 300, 16};
    int ph_minp[NUM_PHASES]  = '{120, 0, 511, 200, 0, 500, 120};

    superheat_adaptive_step_control_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_tick(item_t'(s_tdata[56:0]));
        if (aresetn && m_tvalid && m_tready) sb.check_word($signed(m_tdata[12:0]), m_tuser[0]);
    end

    function automatic item_t mk(int dis, int inl, int sat, int tgt, int pos);
        item_t it;
        it.discharge_temp   = 12'(dis);
        it.inlet_temp       = 12'(inl);
        it.saturation_temp  = 12'(sat);
        it.superheat_target = 12'(tgt);
        it.valve_position   = 9'(pos);
        return it;
    endfunction

    function automatic item_t rand_tick();
        int roll;
        int dis;
        int tgt;
        int offs;
        int superheat;
        int sat;
        roll = $urandom_range(0, 99);
        if (roll < 8) return item_t'(57'({$urandom(), $urandom()}));
        if (roll < 20) dis = cfg_limit + int'($urandom_range(1, 400));
        else dis = cfg_limit - int'($urandom_range(0, 600));
        if (dis > 2047) dis = 2047;
        if (dis < -2048) dis = -2048;
        if ($urandom_range(0, 9) >= 7) last_want = dir_t'($urandom_range(0, 2));
        tgt = int'($urandom_range(0, 1200)) - 600;
        offs = cfg_band + int'($urandom_range(1, 40));
        case (last_want)
            DIR_FWD:  superheat = tgt + offs;
            DIR_BACK: superheat = tgt - offs;
            default:  superheat = tgt + int'($urandom_range(0, 2 * cfg_band)) - cfg_band;
        endcase
        sat = int'($urandom_range(0, 1000)) - 500;
        return mk(dis, sat + superheat, sat, tgt, int'($urandom_range(0, 511)));
    endfunction

    task automatic send_tick(input item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, it};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 12'(val);
        @(posedge aclk);
        sb.set_reg(idx, 12'(val));
    endtask

    task automatic configure(input int lim, input int bnd, input int ini, input int minp);
        put_reg(CFG_DISCHARGE_LIMIT, lim);
        put_reg(CFG_DEADBAND, bnd);
        put_reg(CFG_INITIAL_STEP, ini);
        put_reg(CFG_MIN_POSITION, minp);
        cfg_we <= 1'b0;
        cfg_limit = lim;
        cfg_band = bnd;
    endtask

    task automatic run_directed();
        int i;
        send_tick(mk(1001, 0, 0, 0, 300));
        send_tick(mk(2047, 0, 0, 0, 0));
        send_tick(mk(1000, 105, 0, 100, 300));
        send_tick(mk(-2048, 95, 0, 100, 300));
        for (i = 0; i < 4; i++) send_tick(mk(0, 200, 100, 0, 300));
        for (i = 0; i < 7; i++) send_tick(mk(0, (i % 2 == 0) ? 0 : 200, 100, 0, 300));
        send_tick(mk(0, -500, 500, 0, 0));
        send_tick(mk(0, 2047, -2048, 0, 511));
        send_tick(mk(0, -2048, 2047, 0, 0));
        send_tick(mk(0, 0, 0, 2047, 511));
        send_tick(mk(0, 0, 0, -2048, 511));
        send_tick(mk(-1000, 1500, -1000, 1500, 500));
        send_tick(mk(1500, 0, 0, 0, 0));
    endtask

    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD_CYCLES;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle = 0;
            else idle++;
        end
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int p;
        int n;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        for (p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                configure(ph_limit[p], ph_band[p], ph_init[p], ph_minp[p]);
            end
            for (n = 0; n < TICKS_PER_PHASE; n++) begin
                if (p == 3 && n == 60) long_hold_req = 1'b1;
                if (p == 4 && n == 100) wait_drained();
                no_gaps = (p == 5 && n < 60);
                send_tick(rand_tick());
            end
        end
        wait_drained();
        sb.flush_leftovers();
        $display("ran %0d ticks over %0d register settings; %0d command words, %0d over-limit",
                 sb.ticks, NUM_PHASES, sb.words, sb.over_words);
        $display("saw %0d reversals, %0d step restores, %0d commands held back at minimum",
                 sb.reversals, sb.restores, sb.below_min);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- superheat_adaptive_step_control_unit.f -----
rtl/sasc_pkg.sv
rtl/sasc_step_logic.sv
rtl/superheat_adaptive_step_control_unit.sv
bench/superheat_adaptive_step_control_unit_tb.sv
